// ===== hdl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes for the JSON string unescaper: the input beat, the
// result beat, the status codes and the source characters it recognizes.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // Status codes carried with every result beat
    localparam logic [1:0] ST_WAIT = 2'd0;
    localparam logic [1:0] ST_IN   = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;
    localparam logic [1:0] ST_ERR  = 2'd3;

    // Source characters
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_B       = 8'h62;
    localparam logic [7:0] CH_F       = 8'h66;
    localparam logic [7:0] CH_N       = 8'h6E;
    localparam logic [7:0] CH_R       = 8'h72;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_U       = 8'h75;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    // Decoded control characters
    localparam logic [7:0] CC_BS = 8'h08;
    localparam logic [7:0] CC_FF = 8'h0C;
    localparam logic [7:0] CC_LF = 8'h0A;
    localparam logic [7:0] CC_CR = 8'h0D;
    localparam logic [7:0] CC_HT = 8'h09;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_source;
    } item_t;

    typedef struct packed {
        logic [31:0] out_bytes;
        logic [2:0]  out_count;
        logic [1:0]  status;
    } result_t;

endpackage

// ===== hdl/jsu_if.sv =====
// ----------------------------------------------------------------------------
// jsu_if
// Valid/ready channels for the source byte stream and the decoded stream.
// ----------------------------------------------------------------------------
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_source;

    modport source (output valid, output in_byte, output end_of_source, input ready);
    modport sink   (input valid, input in_byte, input end_of_source, output ready);
endinterface

interface jsu_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_bytes;
    logic [2:0]  out_count;
    logic [1:0]  status;

    modport source (output valid, output out_bytes, output out_count, output status,
                    input ready);
    modport sink   (input valid, input out_bytes, input out_count, input status,
                    output ready);
endinterface

// ===== hdl/jsu_core.sv =====
// ----------------------------------------------------------------------------
// jsu_core
// Decode state machine: one source byte per load, registered result beat.
// ----------------------------------------------------------------------------
module jsu_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  jsu_pkg::item_t  item,
    output jsu_pkg::result_t result
);
    import jsu_pkg::*;

    typedef enum logic [2:0] {
        M_IDLE,
        M_NORMAL,
        M_ESC,
        M_HEX1,
        M_PAIR_BS,
        M_PAIR_U,
        M_HEX2
    } mode_t;

    typedef struct packed {
        logic [31:0] bytes;
        logic [2:0]  count;
    } enc_t;

    mode_t       mode_reg, mode_next;
    logic [1:0]  seen_reg, seen_next;
    logic [15:0] accum_reg, accum_next;
    logic [9:0]  hs_reg, hs_next;
    result_t     result_reg, result_next;

    logic [7:0]  b;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [15:0] unit;
    logic [20:0] pair_cp;
    logic        unit_high, unit_low;
    enc_t        enc_bmp, enc_pair;

    // Encode a code point already known to be valid
    function automatic enc_t utf8_encode(input logic [20:0] cp);
        enc_t e;
        e = '0;
        if (cp <= 21'h7F) begin
            e.bytes = {24'd0, cp[7:0]};
            e.count = 3'd1;
        end
        else if (cp <= 21'h7FF) begin
            e.bytes = {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
            e.count = 3'd2;
        end
        else if (cp <= 21'hFFFF) begin
            e.bytes = {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
            e.count = 3'd3;
        end
        else begin
            e.bytes = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
                       5'b11110, cp[20:18]};
            e.count = 3'd4;
        end
        return e;
    endfunction

    assign b = item.in_byte;

    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = b[3:0];
        if (b >= 8'h30 && b <= 8'h39)
        begin
            hex_val = b[3:0];
        end
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
        begin
            hex_val = b[3:0] + 4'd9;
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    assign unit      = {accum_reg[11:0], hex_val};
    assign unit_high = (unit[15:10] == 6'b110110);
    assign unit_low  = (unit[15:10] == 6'b110111);
    assign pair_cp   = 21'h10000 + {1'b0, hs_reg, unit[9:0]};
    assign enc_bmp   = utf8_encode({5'd0, unit});
    assign enc_pair  = utf8_encode(pair_cp);

    always_comb
    begin
        mode_next   = mode_reg;
        seen_next   = seen_reg;
        accum_next  = accum_reg;
        hs_next     = hs_reg;
        result_next = '0;
        result_next.status = ST_IN;

        if (mode_reg == M_IDLE || mode_reg > M_HEX2)
        begin
            // Wait for the opening quote, drop everything else
            mode_next          = M_IDLE;
            result_next.status = ST_WAIT;
            if (!item.end_of_source && b == CH_QUOTE)
            begin
                mode_next          = M_NORMAL;
                result_next.status = ST_IN;
            end
        end
        else if (item.end_of_source)
        begin
            result_next.status = ST_ERR;
        end
        else
        begin
            case (mode_reg)
                M_NORMAL:
                begin
                    if (b == CH_QUOTE)
                        result_next.status = ST_DONE;
                    else if (b == CH_BSLASH)
                        mode_next = M_ESC;
                    else if (b < CTRL_LIMIT)
                        result_next.status = ST_ERR;
                    else
                    begin
                        result_next.out_bytes = {24'd0, b};
                        result_next.out_count = 3'd1;
                    end
                end
                M_ESC:
                begin
                    mode_next             = M_NORMAL;
                    result_next.out_count = 3'd1;
                    if (b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH)
                        result_next.out_bytes = {24'd0, b};
                    else if (b == CH_B)
                        result_next.out_bytes = {24'd0, CC_BS};
                    else if (b == CH_F)
                        result_next.out_bytes = {24'd0, CC_FF};
                    else if (b == CH_N)
                        result_next.out_bytes = {24'd0, CC_LF};
                    else if (b == CH_R)
                        result_next.out_bytes = {24'd0, CC_CR};
                    else if (b == CH_T)
                        result_next.out_bytes = {24'd0, CC_HT};
                    else
                    begin
                        result_next.out_count = 3'd0;
                        if (b == CH_U)
                        begin
                            mode_next  = M_HEX1;
                            seen_next  = 2'd0;
                            accum_next = 16'd0;
                        end
                        else
                            result_next.status = ST_ERR;
                    end
                end
                M_PAIR_BS:
                begin
                    if (b == CH_BSLASH)
                        mode_next = M_PAIR_U;
                    else
                        result_next.status = ST_ERR;
                end
                M_PAIR_U:
                begin
                    if (b == CH_U)
                    begin
                        mode_next  = M_HEX2;
                        seen_next  = 2'd0;
                        accum_next = 16'd0;
                    end
                    else
                        result_next.status = ST_ERR;
                end
                M_HEX1, M_HEX2:
                begin
                    if (!hex_ok)
                        result_next.status = ST_ERR;
                    else
                    begin
                        accum_next = unit;
                        seen_next  = seen_reg + 2'd1;
                        if (seen_reg == 2'd3)
                        begin
                            // Fourth digit: the unit is complete
                            if (mode_reg == M_HEX1)
                            begin
                                if (unit_high)
                                begin
                                    hs_next   = unit[9:0];
                                    mode_next = M_PAIR_BS;
                                end
                                else if (unit_low)
                                    result_next.status = ST_ERR;
                                else
                                begin
                                    result_next.out_bytes = enc_bmp.bytes;
                                    result_next.out_count = enc_bmp.count;
                                    mode_next             = M_NORMAL;
                                end
                            end
                            else if (unit_low)
                            begin
                                result_next.out_bytes = enc_pair.bytes;
                                result_next.out_count = enc_pair.count;
                                mode_next             = M_NORMAL;
                            end
                            else
                                result_next.status = ST_ERR;
                        end
                    end
                end
                default:
                begin
                    mode_next = M_IDLE;
                end
            endcase
        end

        // Completion or error: clear the decode state and drop the bytes
        if (result_next.status == ST_ERR || result_next.status == ST_DONE)
        begin
            mode_next             = M_IDLE;
            seen_next             = 2'd0;
            accum_next            = 16'd0;
            hs_next               = 10'd0;
            result_next.out_bytes = 32'd0;
            result_next.out_count = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            seen_reg   <= 2'd0;
            accum_reg  <= 16'd0;
            hs_reg     <= 10'd0;
            result_reg <= '0;
        end
        else if (load)
        begin
            mode_reg   <= mode_next;
            seen_reg   <= seen_next;
            accum_reg  <= accum_next;
            hs_reg     <= hs_next;
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ===== hdl/json_string_unescape_utf8.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Turns the source bytes of a JSON string literal into UTF-8 bytes.
// ----------------------------------------------------------------------------
// Path: an accepted source beat is held in the input register, then passes
//   through the decode logic into the result register once that register is free.
// Throughput: one source beat per cycle while the result side keeps taking beats.
// Reset: rst_n clears both valid flags and the decode state; the block then
//   waits for an opening quote.
module json_string_unescape_utf8 (
    input  logic       clk,
    input  logic       rst_n,
    jsu_in_if.sink     text,
    jsu_out_if.source  decoded
);
    import jsu_pkg::*;

    item_t   item_reg;
    logic    item_valid_reg;
    logic    out_valid_reg, out_valid_next;
    logic    advance;
    result_t result;

    // Advance the held byte into decode when the result register is free or
    // being emptied this cycle.
    assign advance    = item_valid_reg && (!out_valid_reg || decoded.ready);
    assign text.ready = !item_valid_reg || advance;

    // Hold the source beat in the input register; payload needs no reset
    always_ff @(posedge clk)
    begin
        if (text.valid && text.ready)
        begin
            item_reg.in_byte       <= text.in_byte;
            item_reg.end_of_source <= text.end_of_source;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (text.ready)
            item_valid_reg <= text.valid;
    end

    // Result beat stays valid until taken; a new one replaces it on advance
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (decoded.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    jsu_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance),
        .item   (item_reg),
        .result (result)
    );

    assign decoded.valid     = out_valid_reg;
    assign decoded.out_bytes = result.out_bytes;
    assign decoded.out_count = result.out_count;
    assign decoded.status    = result.status;

    // A held byte is never lost while the result side stalls
    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !advance |=> item_valid_reg)
        else $error("held source beat dropped");

    // An accepted beat always lands in the input register
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        text.valid && text.ready |=> item_valid_reg)
        else $error("accepted source beat not captured");

    // Completion, error and waiting beats carry no bytes
    a_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (result.status == ST_DONE || result.status == ST_ERR ||
                          result.status == ST_WAIT)
        |-> (result.out_count == 3'd0 && result.out_bytes == 32'd0))
        else $error("bytes emitted outside a string");

    // Never more than four bytes in one beat
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> result.out_count <= 3'd4)
        else $error("byte count out of range");

    // Decode advances only when the result register can take the beat
    a_advance_safe: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("decoded beat lost");

endmodule

// ===== dv/jsu_test_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_test_pkg
// Decode predictor and result scoreboard for the JSON string unescaper test.
// ----------------------------------------------------------------------------
package jsu_test_pkg;

    import jsu_pkg::*;

    // Decoder phases as the predictor tracks them
    typedef enum logic [2:0] {
        DEC_IDLE,
        DEC_TEXT,
        DEC_ESCAPE,
        DEC_UNIT1,
        DEC_PAIR_BSLASH,
        DEC_PAIR_U,
        DEC_UNIT2
    } dec_mode_e;

    localparam logic [4:0]  HEX_NONE        = 5'd16;
    localparam logic [15:0] SURR_HIGH_FIRST = 16'hD800;
    localparam logic [15:0] SURR_HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] SURR_LOW_FIRST  = 16'hDC00;
    localparam logic [15:0] SURR_LOW_LAST   = 16'hDFFF;

    // Value of a hex digit character, HEX_NONE for anything else
    function automatic logic [4:0] hex_nibble(logic [7:0] ch);
        if (ch >= 8'h30 && ch <= 8'h39)
        begin
            return 5'(ch - 8'h30);
        end
        if (ch >= 8'h61 && ch <= 8'h66)
        begin
            return 5'(ch - 8'h57);
        end
        if (ch >= 8'h41 && ch <= 8'h46)
        begin
            return 5'(ch - 8'h37);
        end
        return HEX_NONE;
    endfunction

    class utf8_scoreboard;

        dec_mode_e   mode;
        logic [2:0]  digits_seen;
        logic [15:0] unit_value;
        logic [9:0]  high_bits;

        result_t     expected_utf8_q[$];

        int unsigned mismatches;
        int unsigned source_beats;
        int unsigned checked;
        int unsigned literals_closed;
        int unsigned literals_rejected;
        int unsigned four_byte_seqs;

        function new();
            mode              = DEC_IDLE;
            digits_seen       = '0;
            unit_value        = '0;
            high_bits         = '0;
            mismatches        = 0;
            source_beats      = 0;
            checked           = 0;
            literals_closed   = 0;
            literals_rejected = 0;
            four_byte_seqs    = 0;
        endfunction

        // Pack a valid code point as UTF-8, first byte in the low lane
        function void utf8_encode(input logic [20:0] cp, output logic [31:0] lanes,
                                  output logic [2:0] n);
            if (cp <= 21'h7F)
            begin
                lanes = {24'h0, cp[7:0]};
                n     = 3'd1;
            end
            else if (cp <= 21'h7FF)
            begin
                lanes = {16'h0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
                n     = 3'd2;
            end
            else if (cp <= 21'hFFFF)
            begin
                lanes = {8'h0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
                n     = 3'd3;
            end
            else
            begin
                lanes = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12],
                         5'b11110, cp[20:18]};
                n     = 3'd4;
            end
        endfunction

        // Advance the decoder by one accepted source beat; queue its result
        function void note_source_beat(item_t beat);
            logic [31:0] lanes;
            logic [2:0]  n;
            logic [1:0]  st;
            logic [4:0]  d;
            logic [7:0]  b;
            result_t     r;
            lanes = '0;
            n     = '0;
            st    = ST_IN;
            b     = beat.in_byte;
            source_beats++;
            if (mode == DEC_IDLE)
            begin
                st = ST_WAIT;
                if (!beat.end_of_source && b == CH_QUOTE)
                begin
                    mode = DEC_TEXT;
                    st   = ST_IN;
                end
            end
            else if (beat.end_of_source)
            begin
                st = ST_ERR;
            end
            else
            begin
                case (mode)
                    DEC_TEXT:
                    begin
                        if (b == CH_QUOTE)
                        begin
                            st = ST_DONE;
                        end
                        else if (b == CH_BSLASH)
                        begin
                            mode = DEC_ESCAPE;
                        end
                        else if (b < CTRL_LIMIT)
                        begin
                            st = ST_ERR;
                        end
                        else
                        begin
                            lanes = {24'h0, b};
                            n     = 3'd1;
                        end
                    end
                    DEC_ESCAPE:
                    begin
                        mode = DEC_TEXT;
                        n    = 3'd1;
                        case (b)
                            CH_QUOTE, CH_BSLASH, CH_SLASH: lanes = {24'h0, b};
                            CH_B:    lanes = {24'h0, CC_BS};
                            CH_F:    lanes = {24'h0, CC_FF};
                            CH_N:    lanes = {24'h0, CC_LF};
                            CH_R:    lanes = {24'h0, CC_CR};
                            CH_T:    lanes = {24'h0, CC_HT};
                            CH_U:
                            begin
                                n           = 3'd0;
                                mode        = DEC_UNIT1;
                                digits_seen = '0;
                                unit_value  = '0;
                            end
                            default:
                            begin
                                n  = 3'd0;
                                st = ST_ERR;
                            end
                        endcase
                    end
                    DEC_PAIR_BSLASH:
                    begin
                        if (b == CH_BSLASH)
                        begin
                            mode = DEC_PAIR_U;
                        end
                        else
                        begin
                            st = ST_ERR;
                        end
                    end
                    DEC_PAIR_U:
                    begin
                        if (b == CH_U)
                        begin
                            mode        = DEC_UNIT2;
                            digits_seen = '0;
                            unit_value  = '0;
                        end
                        else
                        begin
                            st = ST_ERR;
                        end
                    end
                    default:
                    begin
                        // collect the hex digits of the first or second unit
                        d = hex_nibble(b);
                        if (d == HEX_NONE)
                        begin
                            st = ST_ERR;
                        end
                        else
                        begin
                            unit_value  = {unit_value[11:0], d[3:0]};
                            digits_seen = digits_seen + 3'd1;
                            if (digits_seen >= 3'd4)
                            begin
                                digits_seen = '0;
                                if (mode == DEC_UNIT1)
                                begin
                                    if (unit_value >= SURR_HIGH_FIRST &&
                                        unit_value <= SURR_HIGH_LAST)
                                    begin
                                        high_bits = unit_value[9:0];
                                        mode      = DEC_PAIR_BSLASH;
                                    end
                                    else if (unit_value >= SURR_LOW_FIRST &&
                                             unit_value <= SURR_LOW_LAST)
                                    begin
                                        st = ST_ERR;
                                    end
                                    else
                                    begin
                                        utf8_encode({5'h0, unit_value}, lanes, n);
                                        mode = DEC_TEXT;
                                    end
                                end
                                else if (unit_value >= SURR_LOW_FIRST &&
                                         unit_value <= SURR_LOW_LAST)
                                begin
                                    utf8_encode(21'h10000 + {1'b0, high_bits, unit_value[9:0]},
                                                lanes, n);
                                    mode = DEC_TEXT;
                                end
                                else
                                begin
                                    st = ST_ERR;
                                end
                            end
                        end
                    end
                endcase
            end

            if (st == ST_ERR || st == ST_DONE)
            begin
                mode        = DEC_IDLE;
                digits_seen = '0;
                unit_value  = '0;
                high_bits   = '0;
                lanes       = '0;
                n           = '0;
            end

            r.out_bytes = lanes;
            r.out_count = n;
            r.status    = st;
            expected_utf8_q.insert(expected_utf8_q.size(), r);
        endfunction

        // Compare one accepted result beat with the oldest expectation
        function void check_decoded_beat(result_t got);
            result_t want;
            if (expected_utf8_q.size() == 0)
            begin
                $error("result beat with nothing expected: bytes %h count %0d status %0d",
                       got.out_bytes, got.out_count, got.status);
                mismatches++;
                return;
            end
            want = expected_utf8_q.pop_front();
            checked++;
            if (got.out_bytes !== want.out_bytes)
            begin
                $error("out_bytes: expected %h, actual %h", want.out_bytes, got.out_bytes);
                mismatches++;
            end
            if (got.out_count !== want.out_count)
            begin
                $error("out_count: expected %0d, actual %0d", want.out_count, got.out_count);
                mismatches++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                mismatches++;
            end
            if (want.status == ST_DONE)
            begin
                literals_closed++;
            end
            if (want.status == ST_ERR)
            begin
                literals_rejected++;
            end
            if (want.out_count == 3'd4)
            begin
                four_byte_seqs++;
            end
        endfunction

    endclass

endpackage

// ===== dv/json_string_unescape_utf8_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_test
// Feeds JSON string literals byte by byte into the unescaper: a short directed
// run over the error and boundary cases, then random literals made mostly of
// well-formed text, escapes and surrogate pairs with a few broken ones mixed
// in. Every result beat is checked against a decode predictor, under random
// stalls on both channels and one long hold-off on the result side.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_test;

    import jsu_pkg::*;
    import jsu_test_pkg::*;

    localparam int unsigned ITEMS_PER_PHASE = 570;
    localparam int unsigned LONG_HOLD       = 400;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned CYCLE_LIMIT     = 200000;

    logic clk;
    logic rst_n;

    jsu_in_if  text_ch ();
    jsu_out_if decoded_ch ();

    json_string_unescape_utf8 i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .text    (text_ch),
        .decoded (decoded_ch)
    );

    utf8_scoreboard board = new();

    item_t       source_q[$];   // source beats waiting to be driven
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_off_left; // result-side hold-off, counted down by the receiver
    int unsigned cycle_count;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------------

    function automatic void push_byte(logic [7:0] b);
        item_t beat;
        beat.in_byte       = b;
        beat.end_of_source = 1'b0;
        source_q.insert(source_q.size(), beat);
    endfunction

    // End of source; the byte lane carries junk the block must ignore
    function automatic void push_end();
        item_t beat;
        beat.in_byte       = 8'($urandom);
        beat.end_of_source = 1'b1;
        source_q.insert(source_q.size(), beat);
    endfunction

    // Hex digit character, letters in random case
    function automatic logic [7:0] hex_char(logic [3:0] v);
        if (v < 4'd10)
        begin
            return 8'h30 + {4'h0, v};
        end
        return ($urandom_range(1) ? 8'h37 : 8'h57) + {4'h0, v};
    endfunction

    // Backslash, 'u', then four hex digits, most significant first
    function automatic void push_unit(logic [15:0] u);
        push_byte(CH_BSLASH);
        push_byte(CH_U);
        for (int i = 3; i >= 0; i--)
        begin
            push_byte(hex_char(u[i*4 +: 4]));
        end
    endfunction

    // Payload bits of a surrogate, leaning toward the range ends
    function automatic logic [9:0] surrogate_bits();
        if ($urandom_range(3) == 0)
        begin
            return $urandom_range(1) ? 10'h3FF : 10'h000;
        end
        return 10'($urandom);
    endfunction

    // Append one literal, with an optional run of ignored noise ahead of it.
    // A broken piece ends the literal in an error, so no closing quote follows.
    function automatic void add_random_literal();
        int unsigned tokens;
        int unsigned pick;
        logic [7:0]  b;
        logic [15:0] u;
        if ($urandom_range(4) == 0)
        begin
            repeat ($urandom_range(3, 1))
            begin
                if ($urandom_range(5) == 0)
                begin
                    push_end();
                end
                else
                begin
                    b = 8'($urandom);
                    if (b != CH_QUOTE)
                    begin
                        push_byte(b);
                    end
                end
            end
        end

        push_byte(CH_QUOTE);
        tokens = ($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(8);
        repeat (tokens)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                // plain byte, printable ASCII or any high byte
                do
                begin
                    b = 8'($urandom_range(8'hFF, CTRL_LIMIT));
                end
                while (b == CH_QUOTE || b == CH_BSLASH);
                push_byte(b);
            end
            else if (pick < 60)
            begin
                push_byte(CH_BSLASH);
                case ($urandom_range(7))
                    0: push_byte(CH_QUOTE);
                    1: push_byte(CH_BSLASH);
                    2: push_byte(CH_SLASH);
                    3: push_byte(CH_B);
                    4: push_byte(CH_F);
                    5: push_byte(CH_N);
                    6: push_byte(CH_R);
                    default: push_byte(CH_T);
                endcase
            end
            else if (pick < 78)
            begin
                // BMP unit: one, two and three byte encodings plus the ends
                case ($urandom_range(4))
                    0: u = 16'($urandom_range(16'h007F));
                    1: u = 16'($urandom_range(16'h07FF, 16'h0080));
                    2: u = 16'($urandom_range(16'hD7FF, 16'h0800));
                    3: u = 16'($urandom_range(16'hFFFF, 16'hE000));
                    default: u = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                endcase
                push_unit(u);
            end
            else if (pick < 96)
            begin
                push_unit(SURR_HIGH_FIRST | {6'h0, surrogate_bits()});
                push_unit(SURR_LOW_FIRST | {6'h0, surrogate_bits()});
            end
            else
            begin
                case ($urandom_range(8))
                    0: push_byte(8'($urandom_range(CTRL_LIMIT - 8'd1)));
                    1:
                    begin
                        // escape letter that is not in the list
                        do
                        begin
                            b = 8'($urandom);
                        end
                        while (b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH ||
                               b == CH_B || b == CH_F || b == CH_N || b == CH_R ||
                               b == CH_T || b == CH_U);
                        push_byte(CH_BSLASH);
                        push_byte(b);
                    end
                    2:
                    begin
                        // non-hex byte somewhere among the four digits
                        push_byte(CH_BSLASH);
                        push_byte(CH_U);
                        repeat ($urandom_range(3))
                        begin
                            push_byte(hex_char(4'($urandom)));
                        end
                        do
                        begin
                            b = 8'($urandom);
                        end
                        while (hex_nibble(b) != HEX_NONE);
                        push_byte(b);
                    end
                    3: push_unit(SURR_LOW_FIRST | {6'h0, surrogate_bits()});
                    4:
                    begin
                        // high surrogate, then anything but a backslash
                        push_unit(SURR_HIGH_FIRST | {6'h0, surrogate_bits()});
                        do
                        begin
                            b = 8'($urandom);
                        end
                        while (b == CH_BSLASH);
                        push_byte(b);
                    end
                    5:
                    begin
                        // high surrogate, backslash, then anything but 'u'
                        push_unit(SURR_HIGH_FIRST | {6'h0, surrogate_bits()});
                        push_byte(CH_BSLASH);
                        do
                        begin
                            b = 8'($urandom);
                        end
                        while (b == CH_U);
                        push_byte(b);
                    end
                    6:
                    begin
                        // high surrogate followed by a unit that is not a low one
                        push_unit(SURR_HIGH_FIRST | {6'h0, surrogate_bits()});
                        do
                        begin
                            u = 16'($urandom);
                        end
                        while (u >= SURR_LOW_FIRST && u <= SURR_LOW_LAST);
                        push_unit(u);
                    end
                    7: push_end();
                    default:
                    begin
                        push_unit(SURR_HIGH_FIRST | {6'h0, surrogate_bits()});
                        push_end();
                    end
                endcase
                return;
            end
        end
        push_byte(CH_QUOTE);
    endfunction

    // ------------------------------------------------------------------------
    // Source side: drain source_q, one beat per handshake
    // ------------------------------------------------------------------------

    // Valid stays high between back-to-back beats; drop it only to idle.
    task automatic drive_source_q();
        item_t beat;
        while (source_q.size() > 0)
        begin
            beat = source_q.pop_front();
            while ($urandom_range(99) < send_idle_pct)
            begin
                text_ch.valid <= 1'b0;
                @(posedge clk);
            end
            text_ch.valid         <= 1'b1;
            text_ch.in_byte       <= beat.in_byte;
            text_ch.end_of_source <= beat.end_of_source;
            @(posedge clk);
            while (!text_ch.ready)
            begin
                @(posedge clk);
            end
            board.note_source_beat(beat);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: random ready, plus the long hold-off when requested
    // ------------------------------------------------------------------------

    initial
    begin
        result_t got;
        decoded_ch.ready <= 1'b0;
        forever
        begin
            if (hold_off_left > 0)
            begin
                // hold ready low so the pipeline fills and backs up into the source
                decoded_ch.ready <= 1'b0;
                hold_off_left--;
            end
            else
            begin
                decoded_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
            @(posedge clk);
            if (rst_n && decoded_ch.valid && decoded_ch.ready)
            begin
                got.out_bytes = decoded_ch.out_bytes;
                got.out_count = decoded_ch.out_count;
                got.status    = decoded_ch.status;
                board.check_decoded_beat(got);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: stop a hung run
    // ------------------------------------------------------------------------

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results still expected",
                 cycle_count, board.expected_utf8_q.size());
        $display("** json_string_unescape_utf8: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        send_idle_pct = 21;
        recv_idle_pct = 54;
        hold_off_left = 0;

        rst_n                 <= 1'b0;
        text_ch.valid         <= 1'b0;
        text_ch.in_byte       <= '0;
        text_ch.end_of_source <= 1'b0;
        repeat (2)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;

        // Directed beats: ignored noise and end of source before the quote,
        // raw high byte, lowest printable byte, then one literal per error:
        // control byte, bad escape, lone low surrogate, bad hex digit,
        // source ending inside the string; finish on an empty literal.
        push_byte(8'h78);
        push_end();
        push_byte(CH_QUOTE);
        push_byte(8'hFF);
        push_byte(CTRL_LIMIT);
        push_byte(CTRL_LIMIT - 8'd1);
        push_byte(CH_QUOTE);
        push_byte(CH_BSLASH);
        push_byte(8'h71);
        push_byte(CH_QUOTE);
        push_unit(SURR_LOW_FIRST);
        push_byte(CH_QUOTE);
        push_byte(CH_BSLASH);
        push_byte(CH_U);
        push_byte(8'h67);
        push_byte(CH_QUOTE);
        push_end();
        push_byte(CH_QUOTE);
        push_byte(CH_QUOTE);

        // Three phases of random literals: sender-light idling, receiver-light
        // idling, then full rate with one long result-side hold-off.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 21;
                    recv_idle_pct = 54;
                end
                1:
                begin
                    send_idle_pct = 54;
                    recv_idle_pct = 21;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    hold_off_left = LONG_HOLD;
                end
            endcase
            while (source_q.size() < ITEMS_PER_PHASE)
            begin
                add_random_literal();
            end
            drive_source_q();
        end
        text_ch.valid <= 1'b0;

        // Wait out every outstanding result, then a few more cycles to catch
        // any stray beat the block might still emit.
        while (board.expected_utf8_q.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES)
        begin
            @(posedge clk);
        end

        $display("Decoded %0d source beats into %0d checked result beats in %0d cycles.",
                 board.source_beats, board.checked, cycle_count);
        $display("Literals closed: %0d, rejected: %0d, four-byte sequences: %0d.",
                 board.literals_closed, board.literals_rejected, board.four_byte_seqs);
        if (board.mismatches == 0 && board.expected_utf8_q.size() == 0)
        begin
            $display("** json_string_unescape_utf8: PASSED **");
        end
        else
        begin
            $display("** json_string_unescape_utf8: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/jsu_pkg.sv
hdl/jsu_if.sv
hdl/jsu_core.sv
hdl/json_string_unescape_utf8.sv
dv/jsu_test_pkg.sv
dv/json_string_unescape_utf8_test.sv
